// ===== rtl/adaptive_average_position_signal_defines.svh =====
// assertion macros shared by the rtl files
// clk and arst_n are taken from the module that uses the macro
`ifndef ADAPTIVE_AVERAGE_POSITION_SIGNAL_DEFINES_SVH
`define ADAPTIVE_AVERAGE_POSITION_SIGNAL_DEFINES_SVH

`ifndef ASSERT_OFF
`define AAPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define AAPS_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define AAPS_ASSERT(lbl, prop, msg)
`define AAPS_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// ===== rtl/aaps_pkg.sv =====
package aaps_pkg;

	localparam int PRICE_W     = 32;
	localparam int WINDOW_MAX  = 64;
	localparam int QUEUE_DEPTH = 16;

	localparam int DIFF_W  = PRICE_W + 1;
	localparam int CHG_W   = PRICE_W + 8;
	localparam int ABS_W   = PRICE_W + 7;
	localparam int SF_W    = 20;
	localparam int AVG_W   = 48;
	localparam int DAY_W   = 32;
	localparam int LEN_W   = $clog2(WINDOW_MAX + 1);
	localparam int RING_AW = $clog2(WINDOW_MAX);
	localparam int Q_AW    = $clog2(QUEUE_DEPTH);
	localparam int Q_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_OPEN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOLD      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ER_SCALE      = 3'd5;

	localparam logic signed [1:0] ACT_NONE = 2'sb00;
	localparam logic signed [1:0] ACT_BUY  = 2'sb01;
	localparam logic signed [1:0] ACT_SELL = 2'sb11;

	localparam int DIV_SRC_W = 19;
	localparam int DIV_QW    = 19;
	localparam int DIV_CNT_W = 5;

	typedef struct packed {
		logic                 start;
		logic [ABS_W-1:0]     rem_init;
		logic [DIV_SRC_W-1:0] src;
		logic [DIV_CNT_W-1:0] steps;
		logic [ABS_W-1:0]     divisor;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [DIV_QW-1:0] quotient;
	} div_rsp_t;

	typedef struct packed {
		logic             rd;
		logic             go;
		logic             buy;
		logic             sell;
		logic [DAY_W-1:0] day;
	} qreq_t;

endpackage

// ===== rtl/aaps_if.sv =====
interface aaps_price_if import aaps_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PRICE_W-1:0] close_price;
	modport source (output valid, output close_price, input ready);
	modport sink (input valid, input close_price, output ready);
endinterface

interface aaps_result_if import aaps_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [AVG_W-1:0] average_value;
	logic                    average_valid;
	logic signed [1:0]       trade_action;
	modport source (output valid, output average_value, output average_valid,
		output trade_action, input ready);
	modport sink (input valid, input average_value, input average_valid,
		input trade_action, output ready);
endinterface

interface aaps_cfg_if import aaps_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/adaptive_average_position_signal.sv =====
// channel   dir  payload                                       transfer when
// prices    in   close_price[31:0] (Q16.16)                    valid && ready
// results   out  average_value[47:0], average_valid, trade_action valid && ready
// cfg       in   index[2:0], data[15:0]                        valid && ready
//
// a warm-up day and the day the window fills skip the ratio steps; a day after the window
// has filled spends most of its time in the shared restoring divider (16, 18 and 19 steps
// for ratio, scaled ratio and smoothing target; the ratio division is skipped for a zero
// sum or a clamped ratio), the rest in two-pass average multiply
// reset clears the sums, average, day counter, queue pointers and registers to defaults;
// the difference ring and entry queue memories hold garbage until written
// a finished result waits in the output register while the next price is taken; a day that
// finishes while that register is still full waits in its last step, with prices held off
`include "adaptive_average_position_signal_defines.svh"

module adaptive_average_position_signal import aaps_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	aaps_price_if.sink    prices,
	aaps_result_if.source results,
	aaps_cfg_if.sink      cfg
);
	typedef enum logic [4:0] {
		S_IDLE, S_SUM, S_ER, S_ERW, S_K, S_KW, S_T, S_TW, S_SF, S_SF2,
		S_AV0, S_AV1, S_AV2, S_AV3, S_DEC, S_DEC2, S_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [6:0]  wl_q;
	logic [6:0]  thr_q;
	logic [4:0]  max_open_q;
	logic [15:0] max_hold_q;
	logic [15:0] gain_q;
	logic [15:0] er_scale_q;

	// running state
	logic [PRICE_W-1:0]      close_q;
	logic [PRICE_W-1:0]      prev_q;
	logic signed [CHG_W-1:0] chg_q;
	logic [ABS_W-1:0]        ab_q;
	logic signed [SF_W-1:0]  sf_q;
	logic signed [AVG_W-1:0] avg_q;
	logic [DAY_W-1:0]        day_q;
	logic [LEN_W-1:0]        len_q;

	// per-item intermediates
	logic signed [17:0] er_q;
	logic signed [18:0] k_q;
	logic signed [SF_W-1:0] t_q;
	logic signed [37:0] prod_q;
	logic [48:0]        ma_q;
	logic [19:0]        mb_q;
	logic               neg_q;
	logic [44:0]        p0_q;
	logic [43:0]        p1_q;
	logic signed [56:0] dev_q;
	logic [38:0]        lim_q;

	// output register
	logic                    res_valid_q;
	logic signed [AVG_W-1:0] res_avg_q;
	logic                    res_avg_valid_q;
	logic signed [1:0]       res_action_q;

	// combinational
	logic [LEN_W-1:0]        len_c;
	logic                    accept;
	logic                    slot_free;
	logic                    past_window;
	logic                    at_window;
	logic                    avg_exists;
	logic [DIFF_W-1:0]       ring_rdata;
	logic signed [DIFF_W-1:0] diff;
	logic signed [DIFF_W-1:0] old;
	logic signed [CHG_W-1:0] chg_n;
	logic [ABS_W-1:0]        ab_n;
	logic [CHG_W-1:0]        chg_mag;
	logic [16:0]             er_mag;
	logic [25:0]             er_num;
	logic signed [18:0]      den;
	logic signed [18:0]      num;
	logic [17:0]             num_mag;
	logic                    den_bad;
	logic                    t_big;
	logic signed [20:0]      tdiff;
	logic signed [37:0]      prod_adj;
	logic signed [21:0]      sf_step;
	logic signed [22:0]      sf_sum;
	logic signed [SF_W-1:0]  sf_sat;
	logic signed [48:0]      dev_base;
	logic [68:0]             pfull;
	logic [52:0]             pr;
	logic signed [55:0]      delta;
	logic signed [55:0]      avg_sum;
	logic signed [AVG_W-1:0] avg_sat;
	logic signed [56:0]      lim_s;
	div_req_t                div_req;
	div_rsp_t                div_rsp;
	qreq_t                   qreq;
	logic signed [1:0]       q_action;

	function automatic logic [DIFF_W-1:0] mag33(input logic signed [DIFF_W-1:0] v);
		mag33 = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
	endfunction

	// ring of day differences, one entry per window slot
	aaps_ram #(.W(DIFF_W), .DEPTH(WINDOW_MAX)) u_ring (
		.clk   (clk),
		.we    ((state_q == S_SUM) && (day_q != '0)),
		.waddr (day_q[RING_AW-1:0]),
		.wdata (diff),
		.re    (accept),
		.raddr (day_q[RING_AW-1:0] - len_c[RING_AW-1:0]),
		.rdata (ring_rdata)
	);

	aaps_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	aaps_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (qreq),
		.max_open (max_open_q),
		.max_hold (max_hold_q),
		.action   (q_action)
	);

	assign prices.ready = state_q == S_IDLE;
	assign accept       = prices.valid && (state_q == S_IDLE);
	assign cfg.ready    = 1'b1;
	assign slot_free    = !res_valid_q || results.ready;

	assign results.valid         = res_valid_q;
	assign results.average_value = res_avg_q;
	assign results.average_valid = res_avg_valid_q;
	assign results.trade_action  = res_action_q;

	always_comb begin
		// window length 0 acts as 1, anything above the ring size as the ring size
		if (wl_q == '0) begin
			len_c = LEN_W'(1);
		end else if (32'(wl_q) > 32'(WINDOW_MAX)) begin
			len_c = LEN_W'(WINDOW_MAX);
		end else begin
			len_c = LEN_W'(wl_q);
		end

		past_window = day_q > DAY_W'(len_q);
		at_window   = day_q == DAY_W'(len_q);
		avg_exists  = day_q >= DAY_W'(len_q);

		// window sums
		diff  = $signed({1'b0, close_q}) - $signed({1'b0, prev_q});
		old   = past_window ? $signed(ring_rdata) : '0;
		chg_n = chg_q - {{(CHG_W-DIFF_W){old[DIFF_W-1]}}, old}
			+ {{(CHG_W-DIFF_W){diff[DIFF_W-1]}}, diff};
		ab_n  = ab_q - ABS_W'(mag33(old)) + ABS_W'(mag33(diff));

		// efficiency ratio and scaled ratio
		chg_mag = chg_q[CHG_W-1] ? CHG_W'(-chg_q) : CHG_W'(chg_q);
		er_mag  = er_q[17] ? 17'(-er_q) : 17'(er_q);
		er_num  = {er_mag, 9'd0};

		// smoothing target (k - 1) / (k + 1)
		den     = k_q + 19'sd65536;
		num     = k_q - 19'sd65536;
		num_mag = num[18] ? 18'(-num) : 18'(num);
		den_bad = den[18] || (den == '0);
		t_big   = {3'd0, num_mag} >= {den[17:0], 3'd0};

		// factor update, quotient toward zero
		tdiff    = {t_q[SF_W-1], t_q} - {sf_q[SF_W-1], sf_q};
		prod_adj = prod_q[37] ? prod_q + 38'sd65535 : prod_q;
		sf_step  = 22'(prod_adj >>> 16);
		sf_sum   = {{3{sf_q[SF_W-1]}}, sf_q} + {sf_step[21], sf_step};
		if (sf_sum > 23'sd524287) begin
			sf_sat = 20'sh7FFFF;
		end else if (sf_sum < -23'sd524288) begin
			sf_sat = 20'sh80000;
		end else begin
			sf_sat = sf_sum[SF_W-1:0];
		end

		// average step from the two partial products
		dev_base = $signed({17'd0, close_q}) - {avg_q[AVG_W-1], avg_q};
		pfull    = {p1_q, 25'd0} + 69'(p0_q);
		pr       = pfull[68:16];
		delta    = neg_q ? -$signed({3'd0, pr}) : $signed({3'd0, pr});
		avg_sum  = {{8{avg_q[AVG_W-1]}}, avg_q} + delta;
		if (avg_sum > 56'sh007FFFFFFFFFFF) begin
			avg_sat = {1'b0, {(AVG_W-1){1'b1}}};
		end else if (avg_sum < -56'sh00800000000000) begin
			avg_sat = {1'b1, {(AVG_W-1){1'b0}}};
		end else begin
			avg_sat = avg_sum[AVG_W-1:0];
		end

		lim_s = $signed({18'd0, lim_q});
	end

	// divider launches and queue requests by state
	always_comb begin
		div_req = '0;
		qreq    = '0;
		qreq.day = day_q;
		qreq.rd  = accept;
		case (state_q)
			S_ER: begin
				if ((ab_q != '0) && (chg_mag < {1'b0, ab_q})) begin
					div_req.start    = 1'b1;
					div_req.rem_init = chg_mag[ABS_W-1:0];
					div_req.steps    = DIV_CNT_W'(16);
					div_req.divisor  = ab_q;
				end
			end
			S_K: begin
				div_req.start    = 1'b1;
				div_req.rem_init = ABS_W'(er_num[25:18]);
				div_req.src      = {er_num[17:0], 1'b0};
				div_req.steps    = DIV_CNT_W'(18);
				div_req.divisor  = ABS_W'({1'b0, er_scale_q} + 17'd256);
			end
			S_T: begin
				if (!den_bad && !t_big) begin
					div_req.start    = 1'b1;
					div_req.rem_init = ABS_W'(num_mag[17:3]);
					div_req.src      = {num_mag[2:0], 16'd0};
					div_req.steps    = DIV_CNT_W'(19);
					div_req.divisor  = ABS_W'(den[17:0]);
				end
			end
			S_DEC2: begin
				qreq.go   = 1'b1;
				qreq.buy  = dev_q > lim_s;
				qreq.sell = dev_q < -lim_s;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			wl_q            <= 7'd14;
			thr_q           <= 7'd5;
			max_open_q      <= 5'd1;
			max_hold_q      <= 16'd7;
			gain_q          <= 16'd13107;
			er_scale_q      <= 16'd512;
			close_q         <= '0;
			prev_q          <= '0;
			chg_q           <= '0;
			ab_q            <= '0;
			sf_q            <= '0;
			avg_q           <= '0;
			day_q           <= '0;
			len_q           <= '0;
			er_q            <= '0;
			k_q             <= '0;
			t_q             <= '0;
			prod_q          <= '0;
			ma_q            <= '0;
			mb_q            <= '0;
			neg_q           <= 1'b0;
			p0_q            <= '0;
			p1_q            <= '0;
			dev_q           <= '0;
			lim_q           <= '0;
			res_valid_q     <= 1'b0;
			res_avg_q       <= '0;
			res_avg_valid_q <= 1'b0;
			res_action_q    <= ACT_NONE;
		end else begin
			if (cfg.valid) begin
				case (cfg.index)
					CFG_WINDOW_LENGTH: wl_q       <= cfg.data[6:0];
					CFG_THRESHOLD:     thr_q      <= cfg.data[6:0];
					CFG_MAX_OPEN:      max_open_q <= cfg.data[4:0];
					CFG_MAX_HOLD:      max_hold_q <= cfg.data;
					CFG_GAIN:          gain_q     <= cfg.data;
					CFG_ER_SCALE:      er_scale_q <= cfg.data;
					default: begin
					end
				endcase
			end

			// the result load step refills the register itself
			if (res_valid_q && results.ready && (state_q != S_OUT)) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						close_q <= prices.close_price;
						len_q   <= len_c;
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					// ring entry leaving the window is on the read port now
					if (day_q != '0) begin
						chg_q <= chg_n;
						ab_q  <= ab_n;
					end
					prev_q <= close_q;
					if (past_window) begin
						state_q <= S_ER;
					end else if (at_window) begin
						sf_q    <= 20'sh08000;
						avg_q   <= AVG_W'(close_q);
						state_q <= S_DEC;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_ER: begin
					if (ab_q == '0) begin
						er_q    <= '0;
						state_q <= S_K;
					end else if (chg_mag >= {1'b0, ab_q}) begin
						// ratio clamped to plus or minus one
						er_q    <= chg_q[CHG_W-1] ? -18'sd65536 : 18'sd65536;
						state_q <= S_K;
					end else begin
						state_q <= S_ERW;
					end
				end
				S_ERW: begin
					if (div_rsp.done) begin
						er_q <= chg_q[CHG_W-1] ? -$signed({2'd0, div_rsp.quotient[15:0]})
							: $signed({2'd0, div_rsp.quotient[15:0]});
						state_q <= S_K;
					end
				end
				S_K: begin
					state_q <= S_KW;
				end
				S_KW: begin
					if (div_rsp.done) begin
						k_q <= er_q[17] ? -$signed({1'b0, div_rsp.quotient[17:0]})
							: $signed({1'b0, div_rsp.quotient[17:0]});
						state_q <= S_T;
					end
				end
				S_T: begin
					if (den_bad) begin
						t_q     <= 20'sh80000;
						state_q <= S_SF;
					end else if (t_big) begin
						t_q     <= num[18] ? 20'sh80000 : 20'sh7FFFF;
						state_q <= S_SF;
					end else begin
						state_q <= S_TW;
					end
				end
				S_TW: begin
					if (div_rsp.done) begin
						t_q <= num[18] ? -$signed({1'b0, div_rsp.quotient})
							: $signed({1'b0, div_rsp.quotient});
						state_q <= S_SF;
					end
				end
				S_SF: begin
					prod_q  <= $signed({1'b0, gain_q}) * tdiff;
					state_q <= S_SF2;
				end
				S_SF2: begin
					sf_q    <= sf_sat;
					state_q <= S_AV0;
				end
				S_AV0: begin
					ma_q    <= dev_base[48] ? 49'(-dev_base) : 49'(dev_base);
					mb_q    <= sf_q[SF_W-1] ? 20'(-sf_q) : 20'(sf_q);
					neg_q   <= dev_base[48] ^ sf_q[SF_W-1];
					state_q <= S_AV1;
				end
				S_AV1: begin
					p0_q    <= ma_q[24:0] * mb_q;
					state_q <= S_AV2;
				end
				S_AV2: begin
					p1_q    <= ma_q[48:25] * mb_q;
					state_q <= S_AV3;
				end
				S_AV3: begin
					avg_q   <= avg_sat;
					state_q <= S_DEC;
				end
				S_DEC: begin
					// deviation against threshold, cross multiplied
					dev_q   <= dev_base * 57'sd100;
					lim_q   <= thr_q * close_q;
					state_q <= S_DEC2;
				end
				S_DEC2: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (slot_free) begin
						res_valid_q     <= 1'b1;
						res_avg_q       <= avg_exists ? avg_q : '0;
						res_avg_valid_q <= avg_exists;
						res_action_q    <= avg_exists ? q_action : ACT_NONE;
						day_q           <= day_q + 1'b1;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`AAPS_ASSERT(a_day_hold, state_q != S_OUT |=> day_q == $past(day_q),
		"day counter moved outside result load")
	`AAPS_ASSERT(a_warmup_zero,
		results.valid && !results.average_valid |-> results.average_value == '0
		&& results.trade_action == ACT_NONE, "warm-up result carries data")
	`AAPS_ASSERT_NEVER(a_div_idle, div_rsp.busy && (state_q == S_IDLE || state_q == S_OUT),
		"divider busy outside the ratio steps")
endmodule

// ===== rtl/aaps_ram.sv =====
module aaps_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/aaps_div.sv =====
`include "adaptive_average_position_signal_defines.svh"

module aaps_div import aaps_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [ABS_W-1:0]     rem_q;
	logic [ABS_W-1:0]     div_q;
	logic [DIV_SRC_W-1:0] src_q;
	logic [DIV_QW-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [ABS_W:0]       cand;
	logic                 ge;
	logic [ABS_W:0]       diff;

	// one restoring step per cycle
	assign cand = {rem_q, src_q[DIV_SRC_W-1]};
	assign ge   = cand >= {1'b0, div_q};
	assign diff = cand - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			div_q  <= '0;
			src_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= req.rem_init;
				div_q  <= req.divisor;
				src_q  <= req.src;
				quo_q  <= '0;
				cnt_q  <= req.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[ABS_W-1:0] : cand[ABS_W-1:0];
				src_q <= {src_q[DIV_SRC_W-2:0], 1'b0};
				quo_q <= {quo_q[DIV_QW-2:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

	`AAPS_ASSERT(a_start_idle, req.start |-> !busy_q, "divider started while busy")
	`AAPS_ASSERT(a_busy_cnt, busy_q |-> cnt_q != '0, "divider busy with no steps left")
	`AAPS_ASSERT(a_done_pulse, done_q |=> !done_q && !busy_q, "divider done not a pulse")
endmodule

// ===== rtl/aaps_queue.sv =====
`include "adaptive_average_position_signal_defines.svh"

module aaps_queue import aaps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  qreq_t             req,
	input  logic [4:0]        max_open,
	input  logic [15:0]       max_hold,
	output logic signed [1:0] action
);
	logic [Q_AW-1:0]   head_q;
	logic [Q_CW-1:0]   count_q;
	logic              long_q;
	logic signed [1:0] action_q;
	logic [DAY_W-1:0]  entry;
	logic [Q_CW-1:0]   cap;
	logic              empty;
	logic              held;
	logic              pop;
	logic              same;
	logic              push;
	logic [Q_CW-1:0]   cnt1;
	logic [Q_AW-1:0]   head1;
	logic              room;
	logic              we;
	logic [Q_AW-1:0]   waddr;

	aaps_ram #(.W(DAY_W), .DEPTH(QUEUE_DEPTH)) u_entry_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (req.day),
		.re    (req.rd),
		.raddr (head_q),
		.rdata (entry)
	);

	always_comb begin
		cap   = (32'(max_open) > 32'(QUEUE_DEPTH)) ? Q_CW'(QUEUE_DEPTH) : Q_CW'(max_open);
		empty = count_q == '0;
		held  = (req.day - entry) >= {16'd0, max_hold};
		pop   = !empty && (held || (long_q && req.sell) || (!long_q && req.buy));
		same  = (long_q && req.buy) || (!long_q && req.sell);
		push  = !empty && same && ((count_q < cap) || pop);
		cnt1  = count_q - Q_CW'(pop);
		head1 = head_q + Q_AW'(pop);
		room  = cnt1 < Q_CW'(QUEUE_DEPTH);
		we    = req.go && (empty ? (req.buy || req.sell) : (push && room));
		waddr = empty ? head_q : head1 + cnt1[Q_AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			count_q  <= '0;
			long_q   <= 1'b0;
			action_q <= ACT_NONE;
		end else if (req.go) begin
			if (empty) begin
				if (req.buy || req.sell) begin
					count_q  <= Q_CW'(1);
					long_q   <= req.buy;
					action_q <= req.buy ? ACT_BUY : ACT_SELL;
				end else begin
					action_q <= ACT_NONE;
				end
			end else begin
				head_q  <= head1;
				count_q <= cnt1 + Q_CW'(push && room);
				if (push && pop) begin
					action_q <= ACT_NONE;
				end else if (push) begin
					action_q <= long_q ? ACT_BUY : ACT_SELL;
				end else if (pop) begin
					action_q <= long_q ? ACT_SELL : ACT_BUY;
				end else begin
					action_q <= ACT_NONE;
				end
			end
		end
	end

	assign action = action_q;

	`AAPS_ASSERT(a_count_max, count_q <= Q_CW'(QUEUE_DEPTH), "queue count above depth")
	`AAPS_ASSERT_NEVER(a_buy_sell, req.go && req.buy && req.sell, "buy and sell together")
	`AAPS_ASSERT(a_idle_empty, req.go && empty && !req.buy && !req.sell |=> count_q == '0,
		"empty queue filled without signal")
endmodule

// ===== tb/aaps_checker.sv =====
module aaps_checker import aaps_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	aaps_price_if  prices,
	aaps_result_if results,
	aaps_cfg_if    cfg,
	output int     fail_count,
	output int     pending,
	output int     checked,
	output int     trades
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [AVG_W-1:0] avg;
		logic                    valid;
		logic signed [1:0]       act;
	} day_result_t;

	day_result_t expected_days[$];

	// register copies
	int     win_len, thr_pct, max_open;
	longint hold_limit, gain, er_scale;

	// indicator state
	logic [DIFF_W-1:0] diff_ring [WINDOW_MAX];
	logic [PRICE_W-1:0] last_close;
	longint win_chg, win_abs, sf, avg;
	logic [DAY_W-1:0] day;
	logic [DAY_W-1:0] entry_day [QUEUE_DEPTH];
	int q_head, q_count;
	bit long_pos;

	function automatic longint sx(longint v, int w);
		return (v <<< (64 - w)) >>> (64 - w);
	endfunction

	function automatic longint clip(longint v, int w);
		longint hi, lo;
		hi = (64'sd1 <<< (w - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic longint absval(longint v);
		return v < 0 ? -v : v;
	endfunction

	// sign * floor(|a|*|b| / 2^16)
	function automatic longint scale_q16(longint a, longint b);
		longint unsigned ma, mb, r;
		ma = absval(a);
		mb = absval(b);
		r = (ma >> 16) * mb + (((ma & 64'hFFFF) * mb) >> 16);
		return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic signed [1:0] trade_for_day(longint close, longint a,
			logic [DAY_W-1:0] d);
		longint dev, lim;
		int sig, cap;
		bit drop, add;
		logic [DAY_W-1:0] held;
		dev = (close - a) * 100;
		lim = longint'(thr_pct) * close;
		cap = max_open > QUEUE_DEPTH ? QUEUE_DEPTH : max_open;
		sig = dev > lim ? 1 : (dev < -lim ? -1 : 0);
		if (q_count == 0) begin
			if (sig == 0)
				return ACT_NONE;
			entry_day[q_head] = d;
			q_count = 1;
			long_pos = (sig == 1);
			return sig == 1 ? ACT_BUY : ACT_SELL;
		end
		held = d - entry_day[q_head];
		drop = longint'({32'b0, held}) >= hold_limit;
		drop = drop || (long_pos && sig == -1) || (!long_pos && sig == 1);
		add = ((long_pos && sig == 1) || (!long_pos && sig == -1)) &&
			(q_count < cap || drop);
		if (drop) begin
			q_head = (q_head + 1) % QUEUE_DEPTH;
			q_count--;
		end
		if (add && q_count < QUEUE_DEPTH) begin
			entry_day[(q_head + q_count) % QUEUE_DEPTH] = d;
			q_count++;
		end
		if (add && drop)
			return ACT_NONE;
		if (add)
			return long_pos ? ACT_BUY : ACT_SELL;
		if (drop)
			return long_pos ? ACT_SELL : ACT_BUY;
		return ACT_NONE;
	endfunction

	function automatic day_result_t next_day(logic [PRICE_W-1:0] price);
		day_result_t r;
		longint close, diff, chg, ab, old, er, k, den, t;
		logic [DAY_W-1:0] d, back;
		int len;
		close = longint'({32'b0, price});
		d = day;
		len = win_len < 1 ? 1 : (win_len > WINDOW_MAX ? WINDOW_MAX : win_len);
		if (d >= 1) begin
			diff = close - longint'({32'b0, last_close});
			chg = win_chg;
			ab = win_abs;
			if (d > len) begin
				back = d - len;
				old = sx(longint'({31'b0, diff_ring[back[RING_AW-1:0]]}), DIFF_W);
				chg -= old;
				ab -= absval(old);
			end
			chg += diff;
			ab += absval(diff);
			win_chg = sx(chg, CHG_W);
			win_abs = ab & ((64'sd1 <<< ABS_W) - 1);
			diff_ring[d[RING_AW-1:0]] = diff[DIFF_W-1:0];
		end
		last_close = price;
		if (d == len) begin
			sf = 32768;
			avg = close;
		end else if (d > len) begin
			er = 0;
			if (win_abs != 0) begin
				er = (win_chg * 65536) / win_abs;
				if (er > 65536) er = 65536;
				if (er < -65536) er = -65536;
			end
			k = (er * 512) / (er_scale + 256);
			den = k + 65536;
			if (den <= 0)
				t = -(64'sd1 <<< 62);
			else
				t = ((k - 65536) * 65536) / den;
			t = clip(t, SF_W);
			sf = clip(sf + (gain * (t - sf)) / 65536, SF_W);
			avg = clip(avg + scale_q16(close - avg, sf), AVG_W);
		end
		r.valid = (d >= len);
		r.avg = r.valid ? avg[AVG_W-1:0] : '0;
		r.act = r.valid ? trade_for_day(close, avg, d) : ACT_NONE;
		day = d + 1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_len = 14; thr_pct = 5; max_open = 1;
			hold_limit = 7; gain = 13107; er_scale = 512;
			last_close = '0; win_chg = 0; win_abs = 0; sf = 0; avg = 0; day = '0;
			q_head = 0; q_count = 0; long_pos = 0;
			expected_days.delete();
			fail_count <= 0; pending <= 0; checked <= 0; trades <= 0;
		end else begin
			// results first, a price taken at this edge cannot be answered yet
			if (results.valid && results.ready) begin
				if (expected_days.size() == 0) begin
					$display("%0t: result with nothing expected: avg %0d valid %0b act %0d",
						$time, results.average_value, results.average_valid,
						results.trade_action);
					fail_count <= fail_count + 1;
				end else begin
					day_result_t e;
					e = expected_days.pop_front();
					if (e.avg !== results.average_value || e.valid !== results.average_valid ||
							e.act !== results.trade_action) begin
						$display("%0t: mismatch: expected avg %0d valid %0b act %0d, got avg %0d valid %0b act %0d",
							$time, e.avg, e.valid, e.act, results.average_value,
							results.average_valid, results.trade_action);
						fail_count <= fail_count + 1;
					end
					if (e.act != ACT_NONE)
						trades <= trades + 1;
					checked <= checked + 1;
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_WINDOW_LENGTH: win_len = int'(cfg.data[6:0]);
					CFG_THRESHOLD:     thr_pct = int'(cfg.data[6:0]);
					CFG_MAX_OPEN:      max_open = int'(cfg.data[4:0]);
					CFG_MAX_HOLD:      hold_limit = longint'(cfg.data);
					CFG_GAIN:          gain = longint'(cfg.data);
					CFG_ER_SCALE:      er_scale = longint'(cfg.data);
					default: ;
				endcase
			end
			if (prices.valid && prices.ready)
				expected_days.push_back(next_day(prices.close_price));
			pending <= expected_days.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
module testbench import aaps_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 20000;   // cycles with no transfer before giving up
	localparam int HOLD_OFF    = 400;     // long receiver stall for the pressure phase

	logic clk;
	logic arst_n;

	aaps_price_if  px();
	aaps_result_if rx();
	aaps_cfg_if    cx();

	int fail_count, pending, checked, trades;
	int sent, settings;
	bit steady;      // no idling on either side
	bit hold_now;    // ask the receiver for one long stall
	longint walk;    // running price level for well-formed sequences

	adaptive_average_position_signal u_dut (
		.clk(clk), .arst_n(arst_n), .prices(px), .results(rx), .cfg(cx)
	);

	aaps_checker u_checker (
		.clk(clk), .arst_n(arst_n), .prices(px), .results(rx), .cfg(cx),
		.fail_count(fail_count), .pending(pending), .checked(checked), .trades(trades)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// every input known from time zero
	initial begin
		px.valid = 0; px.close_price = '0;
		cx.valid = 0; cx.index = CFG_WINDOW_LENGTH; cx.data = '0;
		rx.ready = 0;
		steady = 0; hold_now = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	// result side: random stalls, steady stretch, one long hold-off
	initial begin : receiver
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_now && !hold_done) begin
				hold_left = HOLD_OFF;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rx.ready <= 0;
			end else if (steady)
				rx.ready <= 1;
			else
				rx.ready <= ($urandom_range(99) >= 37);
		end
	end

	// watchdog on cycles with no transfer anywhere
	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((px.valid && px.ready) || (rx.valid && rx.ready) || (cx.valid && cx.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: timeout, %0d results still expected", $time, pending);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// all six registers back to back; valid stays up between transfers
	task automatic write_settings(input int wl, input int thr, input int mo,
			input int hd, input int g, input int es);
		logic [CFG_IDX_W-1:0] idx [6];
		int val [6];
		idx = '{CFG_WINDOW_LENGTH, CFG_THRESHOLD, CFG_MAX_OPEN, CFG_MAX_HOLD,
			CFG_GAIN, CFG_ER_SCALE};
		val = '{wl, thr, mo, hd, g, es};
		for (int i = 0; i < 6; i++) begin
			cx.valid <= 1;
			cx.index <= idx[i];
			cx.data <= val[i][CFG_DATA_W-1:0];
			do @(posedge clk); while (!cx.ready);
		end
		cx.valid <= 0;
		@(posedge clk);
		settings++;
	endtask

	task automatic send_price(input logic [PRICE_W-1:0] p);
		if (!steady)
			while ($urandom_range(99) < 37) begin
				px.valid <= 0;
				@(posedge clk);
			end
		px.valid <= 1;
		px.close_price <= p;
		do @(posedge clk); while (!px.ready);
		sent++;
	endtask

	// registers only change once every result is back and the block has settled
	// one edge first so the count includes the last price taken
	task automatic drain();
		px.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// mostly a random walk with moves around the threshold, some raw noise
	function automatic logic [PRICE_W-1:0] next_price();
		longint step;
		int pick;
		pick = $urandom_range(99);
		if (pick < 85) begin
			step = longint'($urandom_range(0, 32'(walk >> 4)));
			if ($urandom_range(1))
				step = -step;
			walk += step;
			if (walk < 1) walk = 1;
			if (walk > 64'hFFFF_FFFF) walk = 64'hFFFF_FFFF;
			return walk[PRICE_W-1:0];
		end else if (pick < 92)
			return $urandom() | 32'd1;
		else if (pick < 96)
			return 32'hFFFF_FFFF;
		else
			return 32'd1;
	endfunction

	initial begin : stimulus
		logic [PRICE_W-1:0] opening [12];
		sent = 0;
		settings = 0;
		@(posedge arst_n);
		@(posedge clk);

		// defaults, then a price path through warm-up, window fill, buys and sells
		write_settings(14, 5, 1, 7, 13107, 512);
		opening = '{32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
			32'h0055_5555, 32'h00AA_AAAA, 32'h0064_0000, 32'h0064_0000, 32'h0064_0000,
			32'h0064_0000, 32'h0064_0000};
		foreach (opening[i])
			send_price(opening[i]);
		// window full: jump up for a buy, keep the price up, then drop for a sell
		send_price(32'h0064_0000);
		send_price(32'h0064_0000);
		send_price(32'h0064_0000);
		send_price(32'h0078_0000);
		for (int i = 0; i < 5; i++)
			send_price(32'h0078_0000);
		send_price(32'h0050_0000);
		send_price(32'h0050_0000);
		send_price(32'h0001_0000);
		send_price(32'hFFFF_FFFF);
		send_price(32'd1);
		drain();

		walk = 64'h0064_0000;
		for (int ph = 0; ph < 8; ph++) begin
			int items;
			case (ph)
				0: write_settings(1, 0, 1, 1, 0, 257);
				1: write_settings(64, 100, 16, 65535, 65535, 65535);
				2: write_settings(2, 3, 16, 65535, 65535, 257);
				default: write_settings($urandom_range(1, 12), $urandom_range(0, 8),
					$urandom_range(1, 16),
					$urandom_range(3) == 0 ? $urandom_range(1, 65535) : $urandom_range(1, 30),
					$urandom_range(0, 65535), $urandom_range(257, 65535));
			endcase
			steady = (ph == 4);
			hold_now = (ph == 5);
			items = (ph == 1) ? 130 : 100;
			if (ph == 0)
				walk = 64'h0000_0100;
			else if (ph == 3)
				walk = 64'hF000_0000;
			for (int i = 0; i < items; i++)
				send_price(next_price());
			drain();
			steady = 0;
		end

		$display("%0d prices sent under %0d register settings, %0d results checked, %0d trades",
			sent, settings, checked, trades);
		$display("covered warm-up, full windows of 1 to 64 days, buys, sells and position limits");
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/aaps_pkg.sv
rtl/aaps_if.sv
rtl/aaps_ram.sv
rtl/aaps_div.sv
rtl/aaps_queue.sv
rtl/adaptive_average_position_signal.sv
tb/aaps_checker.sv
tb/testbench.sv
